// ===== rtl/core/tce_pkg.sv =====
// shared constants, types and codes for the text console engine
package tce_pkg;

  localparam int COLS      = 80;
  localparam int ROWS      = 25;
  localparam int CELLS     = COLS * ROWS;
  localparam int LAST_ROW  = CELLS - COLS;

  localparam int POS_W     = 11;
  localparam int COL_W     = $clog2(COLS);
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int COLOR_W   = 4;
  localparam int OP_W      = 2;
  localparam int CELL_W    = CHAR_W + ATTR_W;
  localparam int CFG_IDX_W = 1;

  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [POS_W-1:0]  COLS_P      = POS_W'(COLS);
  localparam logic [POS_W-1:0]  CELLS_P     = POS_W'(CELLS);
  localparam logic [POS_W-1:0]  CELLS_M1    = POS_W'(CELLS - 1);
  localparam logic [POS_W-1:0]  LAST_ROW_P  = POS_W'(LAST_ROW);
  localparam logic [COL_W-1:0]  COLS_M1     = COL_W'(COLS - 1);

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0a;
  localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

  localparam logic [COLOR_W-1:0] FG_COLOR_RST   = 4'd7;
  localparam logic [COLOR_W-1:0] BACK_COLOR_RST = 4'd0;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_BKSP  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FG_COLOR         = 1'b0,
    REG_BACKGROUND_COLOR = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CMD_PUT,
    CMD_NEWLINE,
    CMD_BKSP,
    CMD_CLEAR,
    CMD_READ,
    CMD_READ_NONE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [CHAR_W-1:0]  code;
    logic [POS_W-1:0]   index;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
    logic idle;
  } back_status_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_MOVE,
    ST_FILL,
    ST_CLEAR
  } back_state_t;

endpackage

// ===== rtl/core/tce_front.sv =====
// front end: classifies incoming requests and queues them for the back end
module tce_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        hold,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [tce_pkg::OP_W-1:0]    s_op,
  input  logic [tce_pkg::CHAR_W-1:0]  s_char_code,
  input  logic [tce_pkg::POS_W-1:0]   s_cell_index,
  output logic                        cmd_valid,
  output tce_pkg::cmd_t               cmd,
  input  logic                        cmd_pop,
  output logic [tce_pkg::QCNT_W-1:0]  count
);
  import tce_pkg::*;

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  cmd_t              cls;
  logic              push;

  always_comb begin
    cls.code  = s_char_code;
    cls.index = s_cell_index;
    unique case (op_t'(s_op))
      OP_PUT:   cls.kind = (s_char_code == NEWLINE_CODE) ? CMD_NEWLINE : CMD_PUT;
      OP_BKSP:  cls.kind = CMD_BKSP;
      OP_CLEAR: cls.kind = CMD_CLEAR;
      OP_READ:  cls.kind = (s_cell_index < CELLS_P) ? CMD_READ : CMD_READ_NONE;
      default:  cls.kind = CMD_READ_NONE;
    endcase
  end

  assign s_tready  = (count != QCNT_W'(QDEPTH)) && !hold;
  assign push      = s_tvalid && s_tready;
  assign cmd_valid = (count != '0);
  assign cmd       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, cmd_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/tce_back.sv =====
// back end: screen memory, cursor, sweep sequencer and result register
module tce_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [tce_pkg::ATTR_W-1:0]  attr,
  input  logic                        cmd_valid,
  input  tce_pkg::cmd_t               cmd,
  output logic                        cmd_pop,
  output tce_pkg::back_status_t       status,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tce_pkg::POS_W-1:0]   out_cursor,
  output logic [tce_pkg::CHAR_W-1:0]  out_char,
  output logic [tce_pkg::ATTR_W-1:0]  out_attr
);
  import tce_pkg::*;

  back_state_t       state, state_next;
  logic [POS_W-1:0]  cursor, cursor_next;
  logic [POS_W-1:0]  row_base, row_base_next;
  logic [COL_W-1:0]  col, col_next;
  logic [POS_W-1:0]  ptr, ptr_next;
  logic              wr_pend, wr_pend_next;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata;
  logic              mem_we;
  logic [POS_W-1:0]  mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [POS_W-1:0]  mem_raddr;

  logic              out_free;
  logic              take;
  logic              load;
  logic [POS_W-1:0]  ld_cursor;
  logic [CHAR_W-1:0] ld_char;
  logic [ATTR_W-1:0] ld_attr;
  logic [POS_W-1:0]  cur_dec;

  assign out_free = !out_valid || out_ready;
  assign take     = (state == ST_IDLE) && cmd_valid && out_free;
  assign cur_dec  = cursor - POS_W'(1);

  assign status.init_busy = (state == ST_INIT);
  assign status.idle      = (state == ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (ptr == CELLS_M1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (take) begin
          unique case (cmd.kind)
            CMD_PUT:     if (cursor == CELLS_M1) state_next = ST_MOVE;
            CMD_NEWLINE: if (row_base == LAST_ROW_P) state_next = ST_MOVE;
            CMD_CLEAR:   state_next = ST_CLEAR;
            CMD_READ:    state_next = ST_READ;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_next = ST_IDLE;
      ST_MOVE: begin
        if (ptr == LAST_ROW_P) state_next = ST_FILL;
      end
      ST_FILL, ST_CLEAR: begin
        if (ptr == CELLS_M1) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    cmd_pop       = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = ptr;
    mem_wdata     = {attr, BLANK_CODE};
    mem_raddr     = ptr + COLS_P;
    cursor_next   = cursor;
    row_base_next = row_base;
    col_next      = col;
    ptr_next      = ptr;
    wr_pend_next  = 1'b0;
    load          = 1'b0;
    ld_cursor     = cursor;
    ld_char       = '0;
    ld_attr       = '0;
    unique case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {RESET_ATTR, BLANK_CODE};
        ptr_next  = (ptr == CELLS_M1) ? '0 : ptr + POS_W'(1);
      end
      ST_IDLE: begin
        if (take) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            CMD_PUT: begin
              mem_we    = 1'b1;
              mem_waddr = cursor;
              mem_wdata = {attr, cmd.code};
              if (cursor == CELLS_M1) begin
                ptr_next = '0;
              end else begin
                cursor_next = cursor + POS_W'(1);
                if (col == COLS_M1) begin
                  col_next      = '0;
                  row_base_next = row_base + COLS_P;
                end else begin
                  col_next = col + COL_W'(1);
                end
                load      = 1'b1;
                ld_cursor = cursor + POS_W'(1);
              end
            end
            CMD_NEWLINE: begin
              if (row_base == LAST_ROW_P) begin
                ptr_next = '0;
              end else begin
                cursor_next   = row_base + COLS_P;
                row_base_next = row_base + COLS_P;
                col_next      = '0;
                load          = 1'b1;
                ld_cursor     = row_base + COLS_P;
              end
            end
            CMD_BKSP: begin
              load = 1'b1;
              if (cursor != '0) begin
                mem_we      = 1'b1;
                mem_waddr   = cur_dec;
                cursor_next = cur_dec;
                ld_cursor   = cur_dec;
                if (col == '0) begin
                  col_next      = COLS_M1;
                  row_base_next = row_base - COLS_P;
                end else begin
                  col_next = col - COL_W'(1);
                end
              end
            end
            CMD_CLEAR: begin
              ptr_next      = '0;
              cursor_next   = '0;
              row_base_next = '0;
              col_next      = '0;
            end
            CMD_READ: begin
              mem_raddr = cmd.index;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        load    = 1'b1;
        ld_char = rdata[CHAR_W-1:0];
        ld_attr = rdata[CELL_W-1:CHAR_W];
      end
      ST_MOVE: begin
        // read runs one cell ahead of the write of the row above
        if (ptr != LAST_ROW_P) begin
          ptr_next     = ptr + POS_W'(1);
          wr_pend_next = 1'b1;
        end
        if (wr_pend) begin
          mem_we    = 1'b1;
          mem_waddr = ptr - POS_W'(1);
          mem_wdata = rdata;
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
        if (ptr == CELLS_M1) begin
          ptr_next      = '0;
          cursor_next   = LAST_ROW_P;
          row_base_next = LAST_ROW_P;
          col_next      = '0;
          load          = 1'b1;
          ld_cursor     = LAST_ROW_P;
        end else begin
          ptr_next = ptr + POS_W'(1);
        end
      end
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (ptr == CELLS_M1) begin
          ptr_next  = '0;
          load      = 1'b1;
          ld_cursor = '0;
        end else begin
          ptr_next = ptr + POS_W'(1);
        end
      end
      default: begin
        ptr_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      cursor    <= '0;
      row_base  <= '0;
      col       <= '0;
      ptr       <= '0;
      wr_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      cursor   <= cursor_next;
      row_base <= row_base_next;
      col      <= col_next;
      ptr      <= ptr_next;
      wr_pend  <= wr_pend_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_cursor <= ld_cursor;
      out_char   <= ld_char;
      out_attr   <= ld_attr;
    end
  end

endmodule

// ===== rtl/core/text_console_engine_unit.sv =====
// top level of the text console engine
//
// A character-cell console of 25 rows by 80 columns with a write cursor.
// Requests come in on the s_ channel: s_tuser carries the operation (put
// character, backspace, clear screen, read cell), s_tdata the character
// and the cell number. Every request gives exactly one result on the m_
// channel: the cursor after the operation and, for a read, the cell's
// character and attribute. Colour registers are written through cfg_we,
// cfg_addr and cfg_wdata; the user must write them only while no request
// is in flight; the block itself does not enforce this.
// Put, newline, backspace and an out-of-range read can follow one per
// cycle in the back end while m_tready is high; a read also passes the
// memory read register before its result is loaded. Clear walks all 2000
// cells; a put or newline that runs off the bottom scrolls, which copies
// 1920 cells and blanks 80, bound by the single write port.
// A two-entry queue decouples the input side from the back end, and the
// output register holds a result while m_tready is low; the back end
// then waits and the queue fills before s_tready drops.
// After reset a clearing pass writes blanks with attribute 07h over all
// 2000 cells with s_tready low; colour writes still land.
module text_console_engine_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [23:0]                     s_tdata,  // char_code, cell_index
  input  logic [tce_pkg::OP_W-1:0]        s_tuser,  // op
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [31:0]                     m_tdata,  // cursor, read_char, read_attr
  input  logic                            cfg_we,
  input  logic [tce_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [tce_pkg::COLOR_W-1:0]     cfg_wdata
);
  import tce_pkg::*;

  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] background_color;
  logic               cmd_valid;
  cmd_t               cmd;
  logic               cmd_pop;
  logic [QCNT_W-1:0]  q_count;
  back_status_t       bstat;
  logic [POS_W-1:0]   out_cursor;
  logic [CHAR_W-1:0]  out_char;
  logic [ATTR_W-1:0]  out_attr;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color         <= FG_COLOR_RST;
      background_color <= BACK_COLOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_FG_COLOR:         fg_color         <= cfg_wdata;
        REG_BACKGROUND_COLOR: background_color <= cfg_wdata;
        default:              fg_color         <= fg_color;
      endcase
    end
  end

  tce_front u_front (
    .clk          (clk),
    .rst          (rst),
    .hold         (bstat.init_busy),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_op         (s_tuser),
    .s_char_code  (s_tdata[CHAR_W-1:0]),
    .s_cell_index (s_tdata[CHAR_W+POS_W-1:CHAR_W]),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .count        (q_count)
  );

  tce_back u_back (
    .clk        (clk),
    .rst        (rst),
    .attr       ({background_color, fg_color}),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .status     (bstat),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_cursor (out_cursor),
    .out_char   (out_char),
    .out_attr   (out_attr)
  );

  assign m_tdata = {5'd0, out_attr, out_char, out_cursor};

  // cursor stays on screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_cursor < CELLS_P))
    else $error("cursor result beyond the screen");

  // nothing taken in during the clearing pass
  a_init_no_input: assert property (@(posedge clk) disable iff (rst)
    bstat.init_busy |-> !s_tready)
    else $error("input transfer during clearing pass");

  // no result before the screen is initialised
  a_init_no_result: assert property (@(posedge clk) disable iff (rst)
    bstat.init_busy |-> !m_tvalid)
    else $error("result during clearing pass");

  // queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(QDEPTH))
    else $error("request queue overflow");

  // a command is only taken with a free result slot
  a_pop_slot: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (cmd_valid && bstat.idle && (!m_tvalid || m_tready)))
    else $error("command taken without a free result slot");

endmodule
